// File: sv/e2la_pkg.sv
// Shared constants and the CORDIC arctangent table for the look-angle pipeline.
// No dependencies; used by e2la_cordic and eci_to_look_angle.
`default_nettype none

package e2la_pkg;

    localparam int ANGLE_BITS_DEF  = 16;
    localparam int VECTOR_BITS_DEF = 27;
    // extra fraction bits carried on vectors
    localparam int GUARD           = 16;
    // CORDIC micro-rotations per pass
    localparam int ITERS           = 30;
    // internal angle accumulator width (32-bit turn fraction plus headroom)
    localparam int Z_BITS          = 34;
    // 1/K scaled by 2^30
    localparam logic [29:0] INV_GAIN     = 30'd652032875;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] r;
        begin
            unique case (idx)
                0:       r = 32'd536870912;
                1:       r = 32'd316933406;
                2:       r = 32'd167458907;
                3:       r = 32'd85004756;
                4:       r = 32'd42667331;
                5:       r = 32'd21354465;
                6:       r = 32'd10679838;
                7:       r = 32'd5340245;
                8:       r = 32'd2670163;
                9:       r = 32'd1335087;
                10:      r = 32'd667544;
                11:      r = 32'd333772;
                12:      r = 32'd166886;
                13:      r = 32'd83443;
                14:      r = 32'd41722;
                15:      r = 32'd20861;
                16:      r = 32'd10430;
                17:      r = 32'd5215;
                18:      r = 32'd2608;
                19:      r = 32'd1304;
                20:      r = 32'd652;
                21:      r = 32'd326;
                22:      r = 32'd163;
                23:      r = 32'd81;
                24:      r = 32'd41;
                25:      r = 32'd20;
                26:      r = 32'd10;
                27:      r = 32'd5;
                28:      r = 32'd3;
                29:      r = 32'd1;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/e2la_cordic.sv
// One pipelined CORDIC pass (rotation or vectoring) followed by a three-stage
// gain correction. Depends on e2la_pkg.
`default_nettype none

module e2la_cordic #(
    parameter int W         = 47,
    parameter int ZW        = e2la_pkg::Z_BITS,
    parameter int SIDE_W    = 1,
    parameter bit VECTORING = 1'b0
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_vld,
    input  wire logic signed [W-1:0]  x_in,
    input  wire logic signed [W-1:0]  y_in,
    input  wire logic signed [ZW-1:0] z_in,
    input  wire logic [SIDE_W-1:0]    side_in,
    output logic                      out_vld,
    output logic signed [W-1:0]       x_out,
    output logic signed [W-1:0]       y_out,
    output logic signed [ZW-1:0]      z_out,
    output logic [SIDE_W-1:0]         side_out
);

    localparam int N = e2la_pkg::ITERS;

    logic                v_reg    [N];
    logic signed [W-1:0] x_reg    [N];
    logic signed [W-1:0] y_reg    [N];
    logic signed [ZW-1:0] z_reg   [N];
    logic [SIDE_W-1:0]   side_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        localparam logic signed [ZW-1:0] ATAN = ZW'(e2la_pkg::atan_turn(i));
        logic signed [W-1:0]  xi;
        logic signed [W-1:0]  yi;
        logic signed [ZW-1:0] zi;
        logic [SIDE_W-1:0]    si;
        logic                 vi;
        logic                 dir;

        if (i == 0)
        begin : g_first
            assign xi = x_in;
            assign yi = y_in;
            assign zi = z_in;
            assign si = side_in;
            assign vi = in_vld;
        end
        else
        begin : g_next
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign si = side_reg[i-1];
            assign vi = v_reg[i-1];
        end

        // vectoring drives y toward zero, rotation drives z toward zero
        assign dir = VECTORING ? yi[W-1] : !zi[ZW-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (dir)
                begin
                    x_reg[i] <= xi - (yi >>> i);
                    y_reg[i] <= yi + (xi >>> i);
                    z_reg[i] <= zi - ATAN;
                end
                else
                begin
                    x_reg[i] <= xi + (yi >>> i);
                    y_reg[i] <= yi - (xi >>> i);
                    z_reg[i] <= zi + ATAN;
                end
                side_reg[i] <= si;
            end
        end
    end

    // gain correction: split magnitude at bit 30, two partial products
    logic               g1_vld_reg, g2_vld_reg, g3_vld_reg;
    logic [W-1:0]       g1_mx_reg, g1_my_reg;
    logic               g1_sx_reg, g1_sy_reg, g2_sx_reg, g2_sy_reg;
    logic signed [ZW-1:0] g1_z_reg, g2_z_reg, g3_z_reg;
    logic [SIDE_W-1:0]  g1_side_reg, g2_side_reg, g3_side_reg;
    logic [W-1:0]       g2_hx_reg, g2_hy_reg;
    logic [59:0]        g2_lx_reg, g2_ly_reg;
    logic signed [W-1:0] g3_x_reg, g3_y_reg;
    logic [W-1:0]       rx_next, ry_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_vld_reg <= 1'b0;
            g2_vld_reg <= 1'b0;
            g3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            g1_vld_reg <= v_reg[N-1];
            g2_vld_reg <= g1_vld_reg;
            g3_vld_reg <= g2_vld_reg;
        end
    end

    assign rx_next = g2_hx_reg + W'(g2_lx_reg[59:30]);
    assign ry_next = g2_hy_reg + W'(g2_ly_reg[59:30]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g1_sx_reg   <= x_reg[N-1][W-1];
            g1_sy_reg   <= y_reg[N-1][W-1];
            g1_mx_reg   <= x_reg[N-1][W-1] ? W'(-x_reg[N-1]) : W'(x_reg[N-1]);
            g1_my_reg   <= y_reg[N-1][W-1] ? W'(-y_reg[N-1]) : W'(y_reg[N-1]);
            g1_z_reg    <= z_reg[N-1];
            g1_side_reg <= side_reg[N-1];

            g2_hx_reg   <= W'(g1_mx_reg[W-1:30] * e2la_pkg::INV_GAIN);
            g2_hy_reg   <= W'(g1_my_reg[W-1:30] * e2la_pkg::INV_GAIN);
            g2_lx_reg   <= g1_mx_reg[29:0] * e2la_pkg::INV_GAIN;
            g2_ly_reg   <= g1_my_reg[29:0] * e2la_pkg::INV_GAIN;
            g2_sx_reg   <= g1_sx_reg;
            g2_sy_reg   <= g1_sy_reg;
            g2_z_reg    <= g1_z_reg;
            g2_side_reg <= g1_side_reg;

            g3_x_reg    <= g2_sx_reg ? -$signed(rx_next) : $signed(rx_next);
            g3_y_reg    <= g2_sy_reg ? -$signed(ry_next) : $signed(ry_next);
            g3_z_reg    <= g2_z_reg;
            g3_side_reg <= g2_side_reg;
        end
    end

    assign out_vld  = g3_vld_reg;
    assign x_out    = g3_x_reg;
    assign y_out    = g3_y_reg;
    assign z_out    = g3_z_reg;
    assign side_out = g3_side_reg;

endmodule

`default_nettype wire

// File: sv/eci_to_look_angle.sv
// Top level of the topocentric look-angle pipeline: four CORDIC passes and
// result formatting. Depends on e2la_pkg and e2la_cordic.
//
// Usage:
//  - Request channel: in_valid/in_stall carry sidereal_angle and the inertial
//    observer-to-target vector range_x/y/z (1/1024 km).
//  - Result channel: out_valid/out_stall carry azimuth (from north toward
//    east), elevation, slant_range and zero_range.
//  - Configuration: cfg_wr_en writes cfg_wr_data into the observer latitude.
//    Write it only while no request is in flight.
//  - Throughput: one request per cycle, every cycle the result side accepts.
//  - Depth: the four CORDIC passes of 30 micro-rotations plus 3
//    gain-correction stages each set the depth from acceptance to out_valid;
//    five further stages handle quadrant folding and output rounding.
//  - Stall: while a result sits in the output register and out_stall is
//    high, the whole pipe holds and in_stall rises; nothing is dropped.
//  - Reset: all valid bits clear and the latitude returns to zero; the pipe
//    accepts requests as soon as reset is released.
//  - An all-zero vector yields zero_range = 1 with zero angles and range.
`default_nettype none

module eci_to_look_angle #(
    parameter int ANGLE_BITS  = e2la_pkg::ANGLE_BITS_DEF,
    parameter int VECTOR_BITS = e2la_pkg::VECTOR_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic signed [ANGLE_BITS-1:0]  cfg_wr_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [ANGLE_BITS-1:0]         sidereal_angle,
    input  wire logic signed [VECTOR_BITS-1:0] range_x,
    input  wire logic signed [VECTOR_BITS-1:0] range_y,
    input  wire logic signed [VECTOR_BITS-1:0] range_z,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [ANGLE_BITS-1:0]              azimuth,
    output logic signed [ANGLE_BITS-1:0]       elevation,
    output logic [VECTOR_BITS-1:0]             slant_range,
    output logic                               zero_range
);

    localparam int G   = e2la_pkg::GUARD;
    localparam int W   = VECTOR_BITS + G + 4;
    localparam int ZW  = e2la_pkg::Z_BITS;
    localparam int SH  = 32 - ANGLE_BITS;
    localparam logic [31:0] QT = e2la_pkg::QUARTER_TURN;
    localparam logic [31:0] HT = e2la_pkg::HALF_TURN;
    localparam logic [31:0] AZ_HALF = 32'(1) << (SH - 1);
    localparam logic signed [32:0] EL_HALF = 33'(1) << (SH - 1);
    localparam logic signed [32:0] EL_LIM  = 33'(1) << (ANGLE_BITS - 2);
    localparam logic [W-1:0] RNG_HALF = W'(1) << (G - 1);

    logic en;
    logic signed [ANGLE_BITS-1:0] lat_reg;

    // global advance: hold everything while a result waits on a stalled receiver
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lat_reg <= '0;
        else if (cfg_wr_en)
            lat_reg <= cfg_wr_data;
    end

    // ---------------- stage 0: widen, fold sidereal rotation into +-quarter
    logic [31:0]          ang0, ang0q;
    logic                 flip0, zero0;
    logic signed [W-1:0]  ax0, ey0, up0;
    logic                 s0_vld_reg, s0_zf_reg;
    logic signed [W-1:0]  s0_a_reg, s0_e_reg, s0_up_reg;
    logic signed [ZW-1:0] s0_z_reg;

    assign ang0  = 32'd0 - {sidereal_angle, {SH{1'b0}}};
    assign ang0q = ang0 + QT;
    assign flip0 = ang0q[31];
    assign zero0 = (range_x == '0) && (range_y == '0) && (range_z == '0);
    assign ax0   = {{(W-VECTOR_BITS-G){range_x[VECTOR_BITS-1]}}, range_x, {G{1'b0}}};
    assign ey0   = {{(W-VECTOR_BITS-G){range_y[VECTOR_BITS-1]}}, range_y, {G{1'b0}}};
    assign up0   = {{(W-VECTOR_BITS-G){range_z[VECTOR_BITS-1]}}, range_z, {G{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else if (en)
            s0_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_a_reg  <= flip0 ? -ax0 : ax0;
            s0_e_reg  <= flip0 ? -ey0 : ey0;
            s0_up_reg <= up0;
            s0_z_reg  <= ZW'($signed(flip0 ? (ang0 ^ HT) : ang0));
            s0_zf_reg <= zero0;
        end
    end

    // ---------------- pass 1: rotate (x, y) by minus sidereal angle
    logic                 r1_vld;
    logic signed [W-1:0]  r1_a, r1_e;
    logic [W:0]           r1_side;

    // the residual angle of a rotation pass is not needed downstream
    e2la_cordic #(.W(W), .ZW(ZW), .SIDE_W(W + 1), .VECTORING(1'b0)) u_rot_sidereal (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s0_vld_reg),
        .x_in     (s0_a_reg),
        .y_in     (s0_e_reg),
        .z_in     (s0_z_reg),
        .side_in  ({s0_zf_reg, s0_up_reg}),
        .out_vld  (r1_vld),
        .x_out    (r1_a),
        .y_out    (r1_e),
        .z_out    (),
        .side_out (r1_side)
    );

    // ---------------- stage P2: latitude turn into south-east-up
    logic [31:0]          ang2, ang2q;
    logic                 flip2;
    logic signed [W-1:0]  up1;
    logic                 p2_vld_reg;
    logic signed [W-1:0]  p2_s_reg, p2_u_reg;
    logic signed [ZW-1:0] p2_z_reg;
    logic [W:0]           p2_side_reg;

    assign ang2  = QT - {lat_reg, {SH{1'b0}}};
    assign ang2q = ang2 + QT;
    assign flip2 = ang2q[31];
    assign up1   = r1_side[W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_vld_reg <= 1'b0;
        else if (en)
            p2_vld_reg <= r1_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_s_reg    <= flip2 ? -r1_a : r1_a;
            p2_u_reg    <= flip2 ? -up1 : up1;
            p2_z_reg    <= ZW'($signed(flip2 ? (ang2 ^ HT) : ang2));
            p2_side_reg <= {r1_side[W], r1_e};
        end
    end

    logic                 r2_vld;
    logic signed [W-1:0]  r2_s, r2_u;
    logic [W:0]           r2_side;

    e2la_cordic #(.W(W), .ZW(ZW), .SIDE_W(W + 1), .VECTORING(1'b0)) u_rot_latitude (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (p2_vld_reg),
        .x_in     (p2_s_reg),
        .y_in     (p2_u_reg),
        .z_in     (p2_z_reg),
        .side_in  (p2_side_reg),
        .out_vld  (r2_vld),
        .x_out    (r2_s),
        .y_out    (r2_u),
        .z_out    (),
        .side_out (r2_side)
    );

    // ---------------- stage P3: azimuth vectoring setup, atan2(east, -south)
    logic signed [W-1:0]  hx3, e3;
    logic                 neg3, vz3;
    logic                 p3_vld_reg;
    logic signed [W-1:0]  p3_x_reg, p3_y_reg;
    logic signed [ZW-1:0] p3_z_reg;
    logic [W+1:0]         p3_side_reg;

    assign hx3  = -r2_s;
    assign e3   = r2_side[W-1:0];
    assign neg3 = hx3[W-1];
    assign vz3  = (hx3 == '0) && (e3 == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_vld_reg <= 1'b0;
        else if (en)
            p3_vld_reg <= r2_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_x_reg    <= neg3 ? -hx3 : hx3;
            p3_y_reg    <= neg3 ? -e3 : e3;
            p3_z_reg    <= neg3 ? ZW'(HT) : '0;
            p3_side_reg <= {r2_side[W], vz3, r2_u};
        end
    end

    logic                 v1_vld;
    logic signed [W-1:0]  v1_h;
    logic signed [ZW-1:0] v1_z;
    logic [W+1:0]         v1_side;

    e2la_cordic #(.W(W), .ZW(ZW), .SIDE_W(W + 2), .VECTORING(1'b1)) u_vec_azimuth (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (p3_vld_reg),
        .x_in     (p3_x_reg),
        .y_in     (p3_y_reg),
        .z_in     (p3_z_reg),
        .side_in  (p3_side_reg),
        .out_vld  (v1_vld),
        .x_out    (v1_h),
        .y_out    (),
        .z_out    (v1_z),
        .side_out (v1_side)
    );

    // ---------------- stage P4: elevation vectoring setup, atan2(up, horizontal)
    logic signed [W-1:0]  u4;
    logic [31:0]          az4;
    logic                 neg4, vz4;
    logic                 p4_vld_reg;
    logic signed [W-1:0]  p4_x_reg, p4_y_reg;
    logic signed [ZW-1:0] p4_z_reg;
    logic [33:0]          p4_side_reg;

    assign u4   = v1_side[W-1:0];
    assign az4  = v1_side[W] ? 32'd0 : v1_z[31:0];
    assign neg4 = v1_h[W-1];
    assign vz4  = (v1_h == '0) && (u4 == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p4_vld_reg <= 1'b0;
        else if (en)
            p4_vld_reg <= v1_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_x_reg    <= neg4 ? -v1_h : v1_h;
            p4_y_reg    <= neg4 ? -u4 : u4;
            p4_z_reg    <= neg4 ? ZW'(HT) : '0;
            p4_side_reg <= {v1_side[W+1], vz4, az4};
        end
    end

    logic                 v2_vld;
    logic signed [W-1:0]  v2_r;
    logic signed [ZW-1:0] v2_z;
    logic [33:0]          v2_side;

    e2la_cordic #(.W(W), .ZW(ZW), .SIDE_W(34), .VECTORING(1'b1)) u_vec_elevation (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (p4_vld_reg),
        .x_in     (p4_x_reg),
        .y_in     (p4_y_reg),
        .z_in     (p4_z_reg),
        .side_in  (p4_side_reg),
        .out_vld  (v2_vld),
        .x_out    (v2_r),
        .y_out    (),
        .z_out    (v2_z),
        .side_out (v2_side)
    );

    // ---------------- output stage: round, clamp, saturate
    logic [31:0]            el32, az_sum;
    logic signed [32:0]     el_sum, el_sh, el_cl;
    logic [W-1:0]           rng, rr;
    logic                   zf5;
    logic [ANGLE_BITS-1:0]  az_reg;
    logic signed [ANGLE_BITS-1:0] el_reg;
    logic [VECTOR_BITS-1:0] rng_reg;
    logic                   zr_reg, out_vld_reg;

    assign zf5    = v2_side[33];
    assign el32   = v2_side[32] ? 32'd0 : v2_z[31:0];
    assign az_sum = v2_side[31:0] + AZ_HALF;
    assign el_sum = $signed({el32[31], el32}) + EL_HALF;
    assign el_sh  = el_sum >>> SH;
    assign rng    = v2_r[W-1] ? '0 : W'(v2_r);
    assign rr     = (rng + RNG_HALF) >> G;

    always_comb
    begin
        priority if (el_sh > EL_LIM)
            el_cl = EL_LIM;
        else if (el_sh < -EL_LIM)
            el_cl = -EL_LIM;
        else
            el_cl = el_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= v2_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zr_reg <= zf5;
            if (zf5)
            begin
                az_reg  <= '0;
                el_reg  <= '0;
                rng_reg <= '0;
            end
            else
            begin
                az_reg  <= az_sum[31:SH];
                el_reg  <= el_cl[ANGLE_BITS-1:0];
                rng_reg <= (|rr[W-1:VECTOR_BITS]) ? '1 : rr[VECTOR_BITS-1:0];
            end
        end
    end

    assign out_valid   = out_vld_reg;
    assign azimuth     = az_reg;
    assign elevation   = el_reg;
    assign slant_range = rng_reg;
    assign zero_range  = zr_reg;

`ifndef SYNTHESIS
    // a waiting result must back-pressure the request side
    a_stall_propagates: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("request accepted while result stalled");

    // zero vector forces all geometry to zero
    a_zero_outputs: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_range) |-> (azimuth == '0 && elevation == '0 && slant_range == '0))
        else $error("zero range with nonzero outputs");

    // elevation stays within plus or minus a quarter turn
    a_elev_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed({elevation[ANGLE_BITS-1], elevation})
                           <= $signed(EL_LIM[ANGLE_BITS:0])
                       && $signed({elevation[ANGLE_BITS-1], elevation})
                           >= -$signed(EL_LIM[ANGLE_BITS:0])))
        else $error("elevation out of range");

    // with a free receiver the pipe advances and a held result moves on
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_stall && v2_vld) |=> out_valid)
        else $error("pipeline failed to advance");
`endif

endmodule

`default_nettype wire
